// File: design/lja_pkg.sv
package lja_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned PC_W   = 3;

    localparam logic [DATA_W-1:0] LCG_MULT = 32'h0003_43FD;
    localparam logic [DATA_W-1:0] LCG_INC  = 32'h0026_9EC3;

    localparam logic [PC_W-1:0] ADDR_ACCM = 3'd0;
    localparam logic [PC_W-1:0] ADDR_ACCA = 3'd1;
    localparam logic [PC_W-1:0] ADDR_CADD = 3'd2;
    localparam logic [PC_W-1:0] ADDR_CMUL = 3'd3;
    localparam logic [PC_W-1:0] ADDR_FIN  = 3'd4;

    typedef enum logic [1:0] {
        A_ACC_MUL,
        A_ACC_ADD,
        A_CUR_MUL,
        A_CUR_MUL_P1
    } t_a_sel;

    typedef enum logic [1:0] {
        B_CUR_MUL,
        B_CUR_ADD,
        B_SEED
    } t_b_sel;

    typedef enum logic [1:0] {
        ADD_NONE,
        ADD_CUR_ADD,
        ADD_ACC_ADD
    } t_add_sel;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_ACC_MUL,
        DST_ACC_ADD,
        DST_CUR_ADD,
        DST_CUR_MUL,
        DST_RESULT
    } t_dest;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IF_ZERO,
        JMP_LOOP,
        JMP_DONE
    } t_jmp;

    typedef struct packed {
        t_a_sel   a_sel;
        t_b_sel   b_sel;
        t_add_sel add_sel;
        t_dest    dest;
    } t_ctrl;

    typedef struct packed {
        t_ctrl           ctrl;
        t_jmp            jmp;
        logic [PC_W-1:0] target;
    } t_uword;

    // dest <= a * b + addend, low 32 bits
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        w = '{ctrl: '{A_ACC_MUL, B_SEED, ADD_NONE, DST_NONE}, jmp: JMP_DONE, target: ADDR_ACCM};
        unique case (pc)
            ADDR_ACCM: w = '{ctrl: '{A_ACC_MUL, B_CUR_MUL, ADD_NONE, DST_ACC_MUL},
                             jmp: JMP_IF_ZERO, target: ADDR_CADD};
            ADDR_ACCA: w = '{ctrl: '{A_ACC_ADD, B_CUR_MUL, ADD_CUR_ADD, DST_ACC_ADD},
                             jmp: JMP_NEXT, target: ADDR_ACCM};
            ADDR_CADD: w = '{ctrl: '{A_CUR_MUL_P1, B_CUR_ADD, ADD_NONE, DST_CUR_ADD},
                             jmp: JMP_NEXT, target: ADDR_ACCM};
            ADDR_CMUL: w = '{ctrl: '{A_CUR_MUL, B_CUR_MUL, ADD_NONE, DST_CUR_MUL},
                             jmp: JMP_LOOP, target: ADDR_ACCM};
            ADDR_FIN:  w = '{ctrl: '{A_ACC_MUL, B_SEED, ADD_ACC_ADD, DST_RESULT},
                             jmp: JMP_DONE, target: ADDR_ACCM};
            default:   w = '{ctrl: '{A_ACC_MUL, B_SEED, ADD_NONE, DST_NONE},
                             jmp: JMP_DONE, target: ADDR_ACCM};
        endcase
        return w;
    endfunction

endpackage

// File: design/lja_sequencer.sv
module lja_sequencer #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [COUNT_WIDTH-1:0] i_count,
    input  logic                   i_out_full,
    output lja_pkg::t_ctrl         o_ctrl,
    output logic                   o_busy
);
    import lja_pkg::*;

    localparam int unsigned BIT_W = (COUNT_WIDTH > 1) ? $clog2(COUNT_WIDTH) : 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(COUNT_WIDTH - 1);

    logic                   r_busy, n_busy;
    logic [PC_W-1:0]        r_pc, n_pc;
    logic [BIT_W-1:0]       r_bit, n_bit;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    t_uword                 w_uw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= ADDR_ACCM;
            r_bit  <= '0;
        end else begin
            r_busy <= n_busy;
            r_pc   <= n_pc;
            r_bit  <= n_bit;
        end
        r_count <= n_count;
    end

    always_comb begin
        w_uw    = ucode(r_pc);
        o_ctrl  = w_uw.ctrl;
        n_busy  = r_busy;
        n_pc    = r_pc;
        n_bit   = r_bit;
        n_count = r_count;
        if (!r_busy) begin
            o_ctrl.dest = DST_NONE;
            if (i_start) begin
                n_busy  = 1'b1;
                n_pc    = ADDR_ACCM;
                n_bit   = '0;
                n_count = i_count;
            end
        end else begin
            unique case (w_uw.jmp)
                JMP_NEXT: n_pc = r_pc + 1'b1;
                JMP_IF_ZERO: begin
                    if (!r_count[0]) begin
                        o_ctrl.dest = DST_NONE;
                        n_pc        = w_uw.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
                JMP_LOOP: begin
                    n_count = r_count >> 1;
                    n_bit   = r_bit + 1'b1;
                    n_pc    = (r_bit != LAST_BIT) ? w_uw.target : r_pc + 1'b1;
                end
                JMP_DONE: begin
                    if (i_out_full) begin
                        o_ctrl.dest = DST_NONE;
                    end else begin
                        n_busy = 1'b0;
                        n_pc   = ADDR_ACCM;
                    end
                end
                default: n_pc = r_pc;
            endcase
        end
    end

    assign o_busy = r_busy;

    a_start_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !r_busy |=> r_busy && r_pc == ADDR_ACCM && r_bit == '0)
        else $error("sequencer did not enter program at start");

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_pc <= ADDR_FIN)
        else $error("program counter out of range");

    a_bits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && r_pc == ADDR_FIN |-> r_bit == BIT_W'(COUNT_WIDTH % (1 << BIT_W)))
        else $error("final step reached with wrong bit count");

endmodule

// File: design/lja_datapath.sv
module lja_datapath (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic [lja_pkg::DATA_W-1:0]   i_seed,
    input  lja_pkg::t_ctrl               i_ctrl,
    output logic [lja_pkg::DATA_W-1:0]   o_result
);
    import lja_pkg::*;

    logic [DATA_W-1:0]   r_acc_mul, r_acc_add, r_cur_mul, r_cur_add, r_seed, r_result;
    logic [DATA_W-1:0]   w_a, w_b, w_add, w_val;
    logic [DATA_W-1:0]   w_prod;

    always_comb begin
        case (i_ctrl.a_sel)
            A_ACC_MUL:    w_a = r_acc_mul;
            A_ACC_ADD:    w_a = r_acc_add;
            A_CUR_MUL:    w_a = r_cur_mul;
            A_CUR_MUL_P1: w_a = r_cur_mul + 1'b1;
            default:      w_a = r_cur_mul;
        endcase
        case (i_ctrl.b_sel)
            B_CUR_MUL: w_b = r_cur_mul;
            B_CUR_ADD: w_b = r_cur_add;
            B_SEED:    w_b = r_seed;
            default:   w_b = r_seed;
        endcase
        case (i_ctrl.add_sel)
            ADD_CUR_ADD: w_add = r_cur_add;
            ADD_ACC_ADD: w_add = r_acc_add;
            default:     w_add = '0;
        endcase
        w_prod = w_a * w_b;
        w_val  = w_prod + w_add;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_acc_mul <= DATA_W'(1);
            r_acc_add <= '0;
            r_cur_mul <= LCG_MULT;
            r_cur_add <= LCG_INC;
            r_seed    <= i_seed;
        end else begin
            case (i_ctrl.dest)
                DST_ACC_MUL: r_acc_mul <= w_val;
                DST_ACC_ADD: r_acc_add <= w_val;
                DST_CUR_ADD: r_cur_add <= w_val;
                DST_CUR_MUL: r_cur_mul <= w_val;
                DST_RESULT:  r_result  <= w_val;
                default: ;
            endcase
        end
    end

    assign o_result = r_result;

endmodule

// File: design/lcg_jump_ahead.sv
// LCG jump-ahead: x' = x * 0x343FD + 0x269EC3 (mod 2^32), skipped forward by n steps.
// Input stream (s_axis): tdata[31:0] start seed, tdata[63:32] step count; only the low
// COUNT_WIDTH bits of the count are used. Output stream (m_axis): tdata = jumped seed.
// One result per input transfer, in order.
// A microcoded sequencer walks the count bits LSB first through one shared 32x32
// multiplier, one product per cycle except while the final step waits for the
// output register: steps ACCM, ACCA, CADD and CMUL for a set bit, ACCM, CADD and
// CMUL for a clear bit, then step FIN for seed * A^n + sum. One item is in flight at
// a time, and tready rises at the clock edge that registers the result. The output
// register lets a new item start while a result waits. If the receiver stalls with a
// result still held, the next item halts at its final step until the output register
// frees. Reset (i_rst_n low, synchronous) drops any item in flight and any pending
// result; tready is high after reset.
module lcg_jump_ahead #(
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // [31:0] start_seed, [63:32] step_count
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata    // [31:0] jumped_seed
);
    import lja_pkg::*;

    logic   w_start, w_busy, w_out_full;
    t_ctrl  w_ctrl;
    logic   r_out_valid, n_out_valid;

    assign o_s_axis_tready = !w_busy;
    assign w_start         = i_s_axis_tvalid && !w_busy;
    assign w_out_full      = r_out_valid && !i_m_axis_tready;

    lja_sequencer #(.COUNT_WIDTH(COUNT_WIDTH)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_count    (i_s_axis_tdata[DATA_W +: COUNT_WIDTH]),
        .i_out_full (w_out_full),
        .o_ctrl     (w_ctrl),
        .o_busy     (w_busy)
    );

    lja_datapath u_dp (
        .i_clk    (i_clk),
        .i_load   (w_start),
        .i_seed   (i_s_axis_tdata[DATA_W-1:0]),
        .i_ctrl   (w_ctrl),
        .o_result (o_m_axis_tdata)
    );

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_m_axis_tready) n_out_valid = 1'b0;
        if (w_ctrl.dest == DST_RESULT) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.dest == DST_RESULT |-> !w_out_full)
        else $error("result register overwritten while held");

    a_valid_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_busy))
        else $error("result appeared without an item in flight");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("accepted a second item while one is in flight");

endmodule

// File: tb/tb_lcg_jump_ahead.sv
`timescale 1ns / 1ps

module tb_lcg_jump_ahead;

    import lja_pkg::*;

    localparam int unsigned CNT_W = 32;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_mode;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata = '0;   // [31:0] start_seed, [63:32] step_count
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [31:0] o_m_axis_tdata;        // [31:0] jumped_seed

    logic [63:0] jobs[$];
    logic [31:0] seeds_due[$];
    logic [31:0] want_seed;

    int n_errors = 0;
    int n_results = 0;
    int burst_left = 1;
    int gap_left = 0;
    int hold_left = 0;
    int next_hold_at = 300;
    int mode_left = 0;
    t_rx_mode rx_mode = RX_OPEN;

    lcg_jump_ahead #(
        .COUNT_WIDTH(CNT_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always #1 i_clk = ~i_clk;

    // square-and-multiply over the count bits, LSB first
    function automatic logic [31:0] jump_seed(input logic [31:0] seed, input logic [31:0] steps);
        logic [31:0] acc_mul;
        logic [31:0] acc_add;
        logic [31:0] cur_mul;
        logic [31:0] cur_add;
        acc_mul = 32'd1;
        acc_add = 32'd0;
        cur_mul = LCG_MULT;
        cur_add = LCG_INC;
        for (int i = 0; i < CNT_W; i++) begin
            if (steps[i]) begin
                acc_mul = acc_mul * cur_mul;
                acc_add = acc_add * cur_mul + cur_add;
            end
            cur_add = (cur_mul + 32'd1) * cur_add;
            cur_mul = cur_mul * cur_mul;
        end
        return acc_mul * seed + acc_add;
    endfunction

    function automatic logic [31:0] pick_count();
        logic [31:0] c;
        case ($urandom_range(0, 5))
            0, 1: c = $urandom;
            2: c = $urandom_range(1, 70);
            3: c = 32'd1 << $urandom_range(0, 31);
            4: c = $urandom | 32'hFFFF_0000;
            default: c = 32'hFFFF_FFFF ^ (32'd1 << $urandom_range(0, 31));
        endcase
        if (c == 32'd0)
            c = 32'd1;
        return c;
    endfunction

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic report(input string what, input logic [31:0] exp_v, input logic [31:0] act_v);
        n_errors++;
        if (n_errors <= 10)
            $display("%s: expected %08h, got %08h", what, exp_v, act_v);
    endtask

    // driver: bursts of transfers with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!(i_s_axis_tvalid && !o_s_axis_tready)) begin
            if (i_s_axis_tvalid) begin
                seeds_due.insert(seeds_due.size(),
                                 jump_seed(i_s_axis_tdata[31:0], i_s_axis_tdata[63:32]));
                void'(jobs.pop_front());
            end
            if (gap_left > 0) begin
                gap_left--;
                i_s_axis_tvalid <= 1'b0;
            end else if (jobs.size() != 0) begin
                i_s_axis_tdata <= jobs[0];
                i_s_axis_tvalid <= 1'b1;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 160)
                                                           : $urandom_range(0, 8);
                end
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, with long hold-offs to back up the input
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else if (n_results >= next_hold_at) begin
            hold_left = 600;
            next_hold_at += 450;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 2));
                mode_left = $urandom_range(30, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                RX_OPEN: i_m_axis_tready <= 1'b1;
                RX_RANDOM: i_m_axis_tready <= $urandom_range(0, 1);
                default: i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            n_results++;
            if (seeds_due.size() == 0) begin
                report("unexpected result transfer", 32'd0, o_m_axis_tdata);
            end else begin
                want_seed = seeds_due.pop_front();
                if (o_m_axis_tdata !== want_seed)
                    report("jumped_seed mismatch", want_seed, o_m_axis_tdata);
            end
        end
    end

    initial begin
        logic [31:0] seed_dir[4];
        logic [31:0] count_dir[6];
        seed_dir = '{32'd0, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA};
        count_dir = '{32'd1, 32'hFFFF_FFFF, 32'h8000_0000, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'd2};
        // zero steps: result is the seed itself
        jobs.insert(jobs.size(), {32'd0, 32'h1234_5678});
        jobs.insert(jobs.size(), {32'd0, 32'hFFFF_FFFF});
        foreach (seed_dir[s])
            foreach (count_dir[c])
                if (s < 2 || c < 2)
                    jobs.insert(jobs.size(), {count_dir[c], seed_dir[s]});
        jobs.insert(jobs.size(), {32'd3, 32'h0000_0001});
        jobs.insert(jobs.size(), {32'h0001_0000, 32'hDEAD_BEEF});
        for (int n = 0; n < 1100; n++)
            jobs.insert(jobs.size(), {pick_count(), pick_seed()});

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (jobs.size() != 0 || i_s_axis_tvalid || seeds_due.size() != 0)
            @(posedge i_clk);
        repeat (150) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("[lcg_jump_ahead] OK");
        end else begin
            $display("[lcg_jump_ahead] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[lcg_jump_ahead] ERROR");
        $finish;
    end

endmodule
